/* rtl/core/can_rx_acceptance_filter_assert.svh */
// Assertion macros shared by the checker.
`ifndef CAN_RX_ACCEPTANCE_FILTER_ASSERT_SVH
`define CAN_RX_ACCEPTANCE_FILTER_ASSERT_SVH

// same-cycle implication
`define CRX_AF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CRX_AF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/crx_af_pkg.sv */
package crx_af_pkg;

    localparam int COUNT_W          = 7;
    localparam int INDEX_W          = 6;
    localparam int HIT_W            = 5;
    localparam int ID_W             = 11;
    localparam int ENTRY_W          = ID_W + 1;
    localparam int MAX_ADDRESSABLE  = 1 << INDEX_W;
    localparam int DEF_NUM_ENTRIES  = 64;
    localparam int NUM_HW_FILTERS   = 32;
    localparam int APB_DATA_W       = 32;
    localparam int APB_ADDR_W       = 2;

    localparam logic [APB_ADDR_W-1:0] ADDR_ENTRY_COUNT = 2'd0;

    localparam logic [ID_W-1:0] SLOT_FREE = 11'h7FF;

    localparam logic ACT_WRITE    = 1'b0;
    localparam logic ACT_CLASSIFY = 1'b1;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_RANGE   = 2'd1;
    localparam logic [1:0] STATUS_NO_SLOT = 2'd2;

    typedef struct packed {
        logic               action;
        logic [INDEX_W-1:0] entry_index;
        logic [ID_W-1:0]    ident;
        logic [ID_W-1:0]    mask;
        logic               rtr;
        logic [HIT_W-1:0]   filter_hit;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               matched;
        logic [INDEX_W-1:0] match_index;
        logic [1:0]         mask_slot;
    } res_t;

    typedef struct packed {
        logic load;
        logic write_entry;
        logic issue_hit;
        logic issue_scan;
        logic emit_match;
        logic emit_miss;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_write;
        logic direct;
        logic hit_ok;
        logic lim_zero;
        logic scan_end;
        logic match_found;
    } dp_status_t;

endpackage

/* rtl/core/crx_af_ram.sv */
module crx_af_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/crx_af_ctrl.sv */
module crx_af_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    output crx_af_pkg::ctrl_cmd_t  cmd,
    input  crx_af_pkg::dp_status_t stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DISPATCH,
        S_HIT,
        S_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.is_write)
                begin
                    cmd.write_entry = 1'b1;
                    state_next      = S_IDLE;
                end
                else if (stat.direct)
                begin
                    if (stat.hit_ok)
                    begin
                        cmd.issue_hit = 1'b1;
                        state_next    = S_HIT;
                    end
                    else
                    begin
                        cmd.emit_miss = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
                else if (stat.lim_zero)
                begin
                    cmd.emit_miss = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    cmd.issue_scan = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_HIT:
            begin
                cmd.emit_match = stat.match_found;
                cmd.emit_miss  = !stat.match_found;
                state_next     = S_IDLE;
            end
            S_SCAN:
            begin
                if (stat.match_found)
                begin
                    cmd.emit_match = 1'b1;
                    state_next     = S_IDLE;
                end
                else if (stat.scan_end)
                begin
                    cmd.emit_miss = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    cmd.issue_scan = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

/* rtl/core/crx_af_dp.sv */
module crx_af_dp #(
    parameter int NUM_ENTRIES = crx_af_pkg::DEF_NUM_ENTRIES
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  crx_af_pkg::req_t                   request,
    input  crx_af_pkg::ctrl_cmd_t              cmd,
    output crx_af_pkg::dp_status_t             stat,
    input  logic                               cfg_we,
    input  logic [crx_af_pkg::COUNT_W-1:0]     cfg_wdata,
    output logic [crx_af_pkg::COUNT_W-1:0]     count,
    output logic                               done,
    output crx_af_pkg::res_t                   result
);

    // entries above the addressable range can never be written
    localparam int STORE_DEPTH = (NUM_ENTRIES < crx_af_pkg::MAX_ADDRESSABLE) ?
                                 NUM_ENTRIES : crx_af_pkg::MAX_ADDRESSABLE;
    localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CW          = crx_af_pkg::COUNT_W;
    localparam int EW          = crx_af_pkg::ENTRY_W;
    localparam logic [CW-1:0] DEPTH_C  = CW'(STORE_DEPTH);
    localparam logic [CW-1:0] DIRECT_C = CW'(crx_af_pkg::NUM_HW_FILTERS);

    crx_af_pkg::req_t          req_reg;
    logic [CW-1:0]             count_reg;
    logic [crx_af_pkg::ID_W-1:0] slots_reg [3];
    logic [crx_af_pkg::ID_W-1:0] slots_next [3];
    logic                      valid_reg [STORE_DEPTH];
    logic [CW-1:0]             addr_reg;
    logic [crx_af_pkg::INDEX_W-1:0] cmp_idx_reg;
    logic                      vld_q_reg;
    logic                      done_reg;
    crx_af_pkg::res_t          res_reg;
    crx_af_pkg::res_t          res_next;

    logic [CW-1:0]             idx_ext;
    logic [CW-1:0]             hit_ext;
    logic [CW-1:0]             lim;
    logic                      idx_ok;
    logic                      direct;
    logic [EW-1:0]             frame;
    logic [1:0]                wr_status;
    logic [1:0]                wr_slot;
    logic                      found;
    logic [AW-1:0]             waddr;
    logic [AW-1:0]             raddr;
    logic                      re;
    logic [2*EW-1:0]           rdata;
    logic [EW-1:0]             rd_ident;
    logic [EW-1:0]             rd_mask;

    assign idx_ext  = {1'b0, req_reg.entry_index};
    assign hit_ext  = {2'b0, req_reg.filter_hit};
    assign direct   = (count_reg <= DIRECT_C);
    assign idx_ok   = (idx_ext < count_reg) && (idx_ext < DEPTH_C);
    assign lim      = (count_reg < DEPTH_C) ? count_reg : DEPTH_C;
    assign frame    = {req_reg.rtr, req_reg.ident};
    assign waddr    = idx_ext[AW-1:0];
    assign re       = cmd.issue_hit || cmd.issue_scan;
    assign raddr    = cmd.issue_hit ? hit_ext[AW-1:0] : addr_reg[AW-1:0];
    assign rd_ident = rdata[EW-1:0];
    assign rd_mask  = rdata[2*EW-1:EW];

    crx_af_ram #(
        .WIDTH (2 * EW),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.write_entry && idx_ok),
        .waddr (waddr),
        .wdata ({1'b1, req_reg.mask, frame}),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    // mask slot allocation for direct mode writes
    always_comb
    begin
        slots_next = slots_reg;
        wr_status  = crx_af_pkg::STATUS_OK;
        wr_slot    = 2'd0;
        found      = 1'b0;
        if (!idx_ok)
        begin
            wr_status = crx_af_pkg::STATUS_RANGE;
        end
        else if (direct && (req_reg.mask != crx_af_pkg::SLOT_FREE))
        begin
            for (int s = 0; s < 3; s++)
            begin
                if (!found && ((slots_reg[s] == req_reg.mask) ||
                               (slots_reg[s] == crx_af_pkg::SLOT_FREE)))
                begin
                    found         = 1'b1;
                    slots_next[s] = req_reg.mask;
                    wr_slot       = 2'(s + 1);
                end
            end
            if (!found)
            begin
                wr_status = crx_af_pkg::STATUS_NO_SLOT;
            end
        end
    end

    always_comb
    begin
        res_next = '0;
        if (cmd.write_entry)
        begin
            res_next.status    = wr_status;
            res_next.mask_slot = wr_slot;
        end
        else if (cmd.emit_match)
        begin
            res_next.matched     = 1'b1;
            res_next.match_index = cmp_idx_reg;
        end
    end

    assign stat.is_write    = (req_reg.action == crx_af_pkg::ACT_WRITE);
    assign stat.direct      = direct;
    assign stat.hit_ok      = (hit_ext < count_reg) && (hit_ext < DEPTH_C);
    assign stat.lim_zero    = (lim == '0);
    assign stat.scan_end    = (addr_reg == lim);
    assign stat.match_found = vld_q_reg && (((frame ^ rd_ident) & rd_mask) == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
            vld_q_reg <= 1'b0;
            addr_reg  <= '0;
            for (int s = 0; s < 3; s++)
            begin
                slots_reg[s] <= crx_af_pkg::SLOT_FREE;
            end
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            done_reg <= cmd.write_entry || cmd.emit_match || cmd.emit_miss;
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
                for (int s = 0; s < 3; s++)
                begin
                    slots_reg[s] <= crx_af_pkg::SLOT_FREE;
                end
                for (int i = 0; i < STORE_DEPTH; i++)
                begin
                    valid_reg[i] <= 1'b0;
                end
            end
            else if (cmd.write_entry && idx_ok)
            begin
                slots_reg <= slots_next;
                valid_reg[waddr] <= 1'b1;
            end
            if (cmd.load)
            begin
                addr_reg <= '0;
            end
            else if (cmd.issue_scan)
            begin
                addr_reg <= addr_reg + 1'b1;
            end
            if (re)
            begin
                vld_q_reg <= valid_reg[raddr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= request;
        end
        if (re)
        begin
            cmp_idx_reg <= cmd.issue_hit ? {1'b0, req_reg.filter_hit}
                                         : addr_reg[crx_af_pkg::INDEX_W-1:0];
        end
        if (cmd.write_entry || cmd.emit_match || cmd.emit_miss)
        begin
            res_reg <= res_next;
        end
    end

    assign count  = count_reg;
    assign done   = done_reg;
    assign result = res_reg;

endmodule

/* rtl/core/can_rx_acceptance_filter.sv */
// CAN receive acceptance filter. A request is taken when start is high and busy is low;
// its single result appears on result for exactly one cycle with done high, and the
// receiver cannot stall it. A new request may be started in the cycle its predecessor's
// result is shown. A write request ends in the dispatch state; a classify request in
// direct mode (entry_count at most 32) reads the entry at filter_hit, or misses from the
// dispatch state when filter_hit lies outside the entries in use; otherwise the entry
// table is scanned through the single read port of its RAM, one entry per cycle, over
// N = min(entry_count, NUM_ENTRIES, 64) entries, ending early at the first matching entry.
// Writing entry_count clears the table at once; no clearing pass is needed.
module can_rx_acceptance_filter #(
    parameter int NUM_ENTRIES = crx_af_pkg::DEF_NUM_ENTRIES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  crx_af_pkg::req_t                    request,
    output logic                                done,
    output crx_af_pkg::res_t                    result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [crx_af_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [crx_af_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [crx_af_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                pready
);

    crx_af_pkg::ctrl_cmd_t             cmd;
    crx_af_pkg::dp_status_t            stat;
    logic                              cfg_we;
    logic [crx_af_pkg::COUNT_W-1:0]    count;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr == crx_af_pkg::ADDR_ENTRY_COUNT);
    assign prdata = (paddr == crx_af_pkg::ADDR_ENTRY_COUNT) ?
                    {{(crx_af_pkg::APB_DATA_W - crx_af_pkg::COUNT_W){1'b0}}, count} : '0;

    crx_af_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    crx_af_dp #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_wdata (pwdata[crx_af_pkg::COUNT_W-1:0]),
        .count     (count),
        .done      (done),
        .result    (result)
    );

endmodule

/* rtl/core/crx_af_checker.sv */
`include "can_rx_acceptance_filter_assert.svh"

module crx_af_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input crx_af_pkg::res_t result
);

    `CRX_AF_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted request did not raise busy")
    `CRX_AF_ASSERT_NOW(a_done_after_busy, done, $past(busy), "result without a request in work")
    `CRX_AF_ASSERT_NOW(a_busy_ends_done, $fell(busy), done, "busy dropped without a result")
    `CRX_AF_ASSERT_NOW(a_match_clean, done && result.matched, (result.status == crx_af_pkg::STATUS_OK) && (result.mask_slot == 2'd0), "match result carries write fields")
    `CRX_AF_ASSERT_NOW(a_miss_index, done && !result.matched, result.match_index == '0, "nonzero index without a match")

endmodule

bind can_rx_acceptance_filter crx_af_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
